>>> sv/skeleton_forward_kinematics_macros.svh
// assertion macros for the skeleton forward kinematics block
// depends on nothing; included by the top file, which checks its own logic
`ifndef SKELETON_FORWARD_KINEMATICS_MACROS_SVH
`define SKELETON_FORWARD_KINEMATICS_MACROS_SVH

// same-cycle implication, disabled during reset
`define SKF_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("skf check failed");

// next-cycle implication, disabled during reset
`define SKF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("skf check failed");

`endif

>>> sv/skf_pkg.sv
// shared types, constants and rounding helpers of the forward kinematics block
// depends on nothing
`default_nettype none

package skf_pkg;

  localparam int MAX_BONES_DEF = 256;
  localparam int ROWS          = 3;

  localparam logic [1:0] LAST_ROW = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QMUL,
    ST_QSUM,
    ST_MMUL,
    ST_MSUM,
    ST_ROW,
    ST_TAIL
  } state_e;

  // 3x3 matrix of Q1.14 entries, [row][col]
  typedef logic [2:0][2:0][15:0] mat_t;
  // three Q15.16 values
  typedef logic [2:0][31:0] vec3_t;
  // three Q1.14 values of one row
  typedef logic [2:0][15:0] row3_t;

  // stage enables of the local rotation datapath
  typedef struct packed {
    logic qmul;
    logic qsum;
    logic mmul;
    logic msum;
  } rot_ctrl_t;

  // control of the parent combine datapath
  typedef struct packed {
    logic       mul;
    logic [1:0] row;
  } xf_ctrl_t;

  // one finished row waiting for transfer
  typedef struct packed {
    logic [7:0]         bone;
    logic signed [15:0] ea;
    logic signed [15:0] eb;
    logic signed [15:0] ec;
    logic signed [31:0] tr;
    logic               bad;
  } out_row_t;

  // round half up by 14 bits, then saturate to 16 bits
  function automatic logic signed [15:0] rnd_sat16(input logic signed [51:0] v);
    logic signed [51:0] t;
    t = (v + 52'sd8192) >>> 14;
    if (t > 52'sd32767) begin
      return 16'sh7fff;
    end else if (t < -52'sd32768) begin
      return 16'sh8000;
    end
    return t[15:0];
  endfunction

  // saturate to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    if (v > 52'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -52'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

`default_nettype wire

>>> sv/skf_store.sv
// world transform store: rotation rows and translations, one entry per bone row
// depends on nothing; synchronous read through a registered output port
`default_nettype none

module skf_store #(
  parameter int DEPTH = 768,
  parameter int AW    = 10
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [47:0]   wrot_i,
  input  wire logic [31:0]   wtr_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [47:0]   rrot_o,
  output logic      [31:0]   rtr_o
);

  logic [47:0] rot_mem [DEPTH];
  logic [31:0] tr_mem  [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      rot_mem[waddr_i] <= wrot_i;
      tr_mem[waddr_i]  <= wtr_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rrot_o <= rot_mem[raddr_i];
      rtr_o  <= tr_mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> sv/skf_rot.sv
// local rotation: quaternion product rest*pose, then conversion to a 3x3 matrix
// depends on skf_pkg; four registered stages under sequencer enables
`default_nettype none

module skf_rot (
  input  wire logic              clk_i,
  input  wire skf_pkg::rot_ctrl_t ctrl_i,
  input  wire logic [63:0]       rest_i,
  input  wire logic [63:0]       pose_i,
  output skf_pkg::mat_t          r_o
);

  logic signed [15:0] qa [4];
  logic signed [15:0] qb [4];
  logic signed [31:0] qp_q [4][4];
  logic signed [33:0] qs [4];
  logic signed [19:0] q_d [4];
  logic signed [19:0] q_q [4];
  // xx yy zz xy xz yz wx wy wz
  logic signed [39:0] mp_q [9];
  logic signed [51:0] e [3][3];
  logic signed [51:0] one;

  // unpack w,x,y,z with w highest
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qa[i] = rest_i[63-16*i -: 16];
      qb[i] = pose_i[63-16*i -: 16];
    end
  end

  // all sixteen component products
  always_ff @(posedge clk_i) begin
    if (ctrl_i.qmul) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          qp_q[i][j] <= qa[i] * qb[j];
        end
      end
    end
  end

  // hamilton sums, rounded to Q14 and kept wide
  always_comb begin
    qs[0] = 34'(qp_q[0][0]) - 34'(qp_q[1][1]) - 34'(qp_q[2][2]) - 34'(qp_q[3][3]);
    qs[1] = 34'(qp_q[0][1]) + 34'(qp_q[1][0]) + 34'(qp_q[2][3]) - 34'(qp_q[3][2]);
    qs[2] = 34'(qp_q[0][2]) - 34'(qp_q[1][3]) + 34'(qp_q[2][0]) + 34'(qp_q[3][1]);
    qs[3] = 34'(qp_q[0][3]) + 34'(qp_q[1][2]) - 34'(qp_q[2][1]) + 34'(qp_q[3][0]);
    for (int i = 0; i < 4; i++) begin
      q_d[i] = 20'((qs[i] + 34'sd8192) >>> 14);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.qsum) begin
      for (int i = 0; i < 4; i++) begin
        q_q[i] <= q_d[i];
      end
    end
  end

  // second order terms of the matrix formula
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mmul) begin
      mp_q[0] <= q_q[1] * q_q[1];
      mp_q[1] <= q_q[2] * q_q[2];
      mp_q[2] <= q_q[3] * q_q[3];
      mp_q[3] <= q_q[1] * q_q[2];
      mp_q[4] <= q_q[1] * q_q[3];
      mp_q[5] <= q_q[2] * q_q[3];
      mp_q[6] <= q_q[0] * q_q[1];
      mp_q[7] <= q_q[0] * q_q[2];
      mp_q[8] <= q_q[0] * q_q[3];
    end
  end

  // matrix entries in Q28
  always_comb begin
    one     = 52'sd268435456;
    e[0][0] = one - ((52'(mp_q[1]) + 52'(mp_q[2])) <<< 1);
    e[0][1] = (52'(mp_q[3]) - 52'(mp_q[8])) <<< 1;
    e[0][2] = (52'(mp_q[4]) + 52'(mp_q[7])) <<< 1;
    e[1][0] = (52'(mp_q[3]) + 52'(mp_q[8])) <<< 1;
    e[1][1] = one - ((52'(mp_q[0]) + 52'(mp_q[2])) <<< 1);
    e[1][2] = (52'(mp_q[5]) - 52'(mp_q[6])) <<< 1;
    e[2][0] = (52'(mp_q[4]) - 52'(mp_q[7])) <<< 1;
    e[2][1] = (52'(mp_q[5]) + 52'(mp_q[6])) <<< 1;
    e[2][2] = one - ((52'(mp_q[0]) + 52'(mp_q[1])) <<< 1);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.msum) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          r_o[i][j] <= skf_pkg::rnd_sat16(e[i][j]);
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/skf_xform.sv
// parent combine: one world row per pass, Rp row times R and Rp row times p plus tp
// depends on skf_pkg; multiply stage registered, sum stage feeds the writeback
`default_nettype none

module skf_xform (
  input  wire logic              clk_i,
  input  wire skf_pkg::xf_ctrl_t ctrl_i,
  input  wire logic [47:0]       prow_i,
  input  wire logic [31:0]       ptr_i,
  input  wire skf_pkg::mat_t     r_i,
  input  wire skf_pkg::vec3_t    p_i,
  input  wire logic              root_i,
  output skf_pkg::row3_t         rw_o,
  output logic [31:0]            tw_o,
  output logic [1:0]             row_o
);

  logic signed [15:0] pr [3];
  logic signed [31:0] pp_q [3][3];
  logic signed [47:0] pt_q [3];
  logic signed [31:0] tp_q;
  logic signed [51:0] s [3];
  logic signed [51:0] acc;
  logic signed [51:0] tsum;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pr[k] = prow_i[16*k +: 16];
    end
  end

  // products of the parent row with the local matrix and position
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          pp_q[k][j] <= pr[k] * $signed(r_i[k][j]);
        end
        pt_q[k] <= pr[k] * $signed(p_i[k]);
      end
      tp_q  <= ptr_i;
      row_o <= ctrl_i.row;
    end
  end

  // sums, rounding and root bypass
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      s[j] = 52'(pp_q[0][j]) + 52'(pp_q[1][j]) + 52'(pp_q[2][j]);
    end
    acc  = 52'(pt_q[0]) + 52'(pt_q[1]) + 52'(pt_q[2]);
    tsum = ((acc + 52'sd8192) >>> 14) + 52'(tp_q);
    if (root_i) begin
      for (int j = 0; j < 3; j++) begin
        rw_o[j] = r_i[row_o][j];
      end
      tw_o = p_i[row_o];
    end else begin
      for (int j = 0; j < 3; j++) begin
        rw_o[j] = skf_pkg::rnd_sat16(s[j]);
      end
      tw_o = skf_pkg::sat32(tsum);
    end
  end

endmodule

`default_nettype wire

>>> sv/skf_obuf.sv
// output buffer: three row slots drained in row order on the master side
// depends on skf_pkg
`default_nettype none

module skf_obuf (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               wr_i,
  input  wire logic [1:0]         wr_row_i,
  input  wire skf_pkg::out_row_t  wr_data_i,
  output logic                    empty_o,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // bone_index[7:0], entry_a[23:8], entry_b[39:24], entry_c[55:40],
  // translation_part[87:56]
  output logic [87:0]             m_axis_tdata,
  // row_index[1:0], bad_parent[2]
  output logic [2:0]              m_axis_tuser,
  output logic                    m_axis_tlast
);

  skf_pkg::out_row_t ent_q [3];
  logic [2:0] v_q, v_d;
  logic [1:0] head_q, head_d;
  logic       xfer;
  skf_pkg::out_row_t hd;

  assign xfer = m_axis_tvalid && m_axis_tready;

  // slot storage
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      ent_q[wr_row_i] <= wr_data_i;
    end
  end

  // valid bits and read pointer
  always_comb begin
    v_d    = v_q;
    head_d = head_q;
    if (xfer) begin
      v_d[head_q] = 1'b0;
      head_d      = (head_q == skf_pkg::LAST_ROW) ? 2'd0 : head_q + 2'd1;
    end
    if (wr_i) begin
      v_d[wr_row_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      head_q <= '0;
    end else begin
      v_q    <= v_d;
      head_q <= head_d;
    end
  end

  // master side
  always_comb begin
    hd            = ent_q[head_q];
    empty_o       = (v_q == 3'b000);
    m_axis_tvalid = v_q[head_q];
    m_axis_tdata  = {hd.tr, hd.ec, hd.eb, hd.ea, hd.bone};
    m_axis_tuser  = {hd.bad, head_q};
    m_axis_tlast  = (head_q == skf_pkg::LAST_ROW);
  end

endmodule

`default_nettype wire

>>> sv/skeleton_forward_kinematics.sv
// an accepted bone passes one at a time through QMUL and QSUM (quaternion product), MMUL and
// MSUM (matrix conversion; MSUM holds until the output buffer is empty), three ROW passes
// (parent rows, through the single read port of the store) and TAIL; bones are taken only in
// IDLE; the next bone is taken while earlier rows still wait on the master side
// reset clears the sequencer, bone counter and output valid bits; the store is not cleared
`default_nettype none
`include "skeleton_forward_kinematics_macros.svh"

module skeleton_forward_kinematics #(
  parameter int MAX_BONES = skf_pkg::MAX_BONES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // parent_index[8:0], rest_rotation[72:9], pose_rotation[136:73], position_x[168:137],
  // position_y[200:169], position_z[232:201], zero[239:233]
  input  wire logic [239:0] s_axis_tdata,
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // bone_index[7:0], entry_a[23:8], entry_b[39:24], entry_c[55:40],
  // translation_part[87:56]
  output logic [87:0]      m_axis_tdata,
  // row_index[1:0], bad_parent[2]
  output logic [2:0]       m_axis_tuser,
  output logic             m_axis_tlast
);

  localparam int DEPTH = skf_pkg::ROWS * MAX_BONES;
  localparam int AW    = $clog2(DEPTH);
  localparam int BW    = $clog2(MAX_BONES);
  localparam int CW    = (BW > 8) ? BW : 8;

  skf_pkg::state_e state_q, state_d;
  logic [BW-1:0]   cnt_q, cnt_d;
  logic [1:0]      rc_q, rc_d;
  logic            sum_v_q;
  logic            accept;

  // captured bone
  logic [BW-1:0]   bone_q;
  logic [63:0]     rest_q, pose_q;
  skf_pkg::vec3_t  p_q;
  logic            root_q, bad_q;
  logic [AW-1:0]   pbase_q, bbase_q;

  logic            neg;
  logic            bad;
  logic [CW-1:0]   pe, be;

  skf_pkg::rot_ctrl_t rot_ctrl;
  skf_pkg::xf_ctrl_t  xf_ctrl;
  skf_pkg::mat_t      r;
  skf_pkg::row3_t     rw;
  skf_pkg::out_row_t  wr_row;
  logic [31:0]        tw;
  logic [1:0]         xf_row;
  logic               re;
  logic [AW-1:0]      raddr;
  logic [47:0]        prow;
  logic [31:0]        ptr;
  logic               ob_empty;

  assign accept = s_axis_tvalid && s_axis_tready;

  // parent check against the current bone number
  always_comb begin
    neg = s_axis_tdata[8];
    pe  = CW'(s_axis_tdata[7:0]);
    be  = CW'(cnt_q);
    bad = !neg && (pe >= be);
  end

  // bone counter
  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      if (s_axis_tlast || (cnt_q == BW'(MAX_BONES - 1))) begin
        cnt_d = '0;
      end else begin
        cnt_d = cnt_q + BW'(1);
      end
    end
  end

  // input capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      bone_q  <= cnt_q;
      rest_q  <= s_axis_tdata[72:9];
      pose_q  <= s_axis_tdata[136:73];
      p_q     <= s_axis_tdata[232:137];
      root_q  <= neg || bad;
      bad_q   <= bad;
      pbase_q <= (neg || bad) ? '0 : AW'({pe, 1'b0}) + AW'(pe);
      bbase_q <= AW'({cnt_q, 1'b0}) + AW'(cnt_q);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    rc_d    = '0;
    case (state_q)
      skf_pkg::ST_IDLE: if (accept) state_d = skf_pkg::ST_QMUL;
      skf_pkg::ST_QMUL: state_d = skf_pkg::ST_QSUM;
      skf_pkg::ST_QSUM: state_d = skf_pkg::ST_MMUL;
      skf_pkg::ST_MMUL: state_d = skf_pkg::ST_MSUM;
      skf_pkg::ST_MSUM: if (ob_empty) state_d = skf_pkg::ST_ROW;
      skf_pkg::ST_ROW: begin
        if (rc_q == skf_pkg::LAST_ROW) begin
          state_d = skf_pkg::ST_TAIL;
        end else begin
          rc_d = rc_q + 2'd1;
        end
      end
      skf_pkg::ST_TAIL: state_d = skf_pkg::ST_IDLE;
      default: state_d = skf_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = (state_q == skf_pkg::ST_IDLE);
    rot_ctrl.qmul = (state_q == skf_pkg::ST_QMUL);
    rot_ctrl.qsum = (state_q == skf_pkg::ST_QSUM);
    rot_ctrl.mmul = (state_q == skf_pkg::ST_MMUL);
    rot_ctrl.msum = (state_q == skf_pkg::ST_MSUM);
    xf_ctrl.mul   = (state_q == skf_pkg::ST_ROW);
    xf_ctrl.row   = rc_q;
    re            = 1'b0;
    raddr         = pbase_q;
    case (state_q)
      skf_pkg::ST_MSUM: re = 1'b1;
      skf_pkg::ST_ROW: begin
        re    = (rc_q != skf_pkg::LAST_ROW);
        raddr = pbase_q + AW'(rc_q) + AW'(1);
      end
      default: re = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= skf_pkg::ST_IDLE;
      cnt_q   <= '0;
      rc_q    <= '0;
      sum_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rc_q    <= rc_d;
      sum_v_q <= (state_q == skf_pkg::ST_ROW);
    end
  end

  skf_rot u_rot (
    .clk_i  (clk_i),
    .ctrl_i (rot_ctrl),
    .rest_i (rest_q),
    .pose_i (pose_q),
    .r_o    (r)
  );

  skf_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (sum_v_q),
    .waddr_i (bbase_q + AW'(xf_row)),
    .wrot_i  (rw),
    .wtr_i   (tw),
    .re_i    (re),
    .raddr_i (raddr),
    .rrot_o  (prow),
    .rtr_o   (ptr)
  );

  skf_xform u_xform (
    .clk_i  (clk_i),
    .ctrl_i (xf_ctrl),
    .prow_i (prow),
    .ptr_i  (ptr),
    .r_i    (r),
    .p_i    (p_q),
    .root_i (root_q),
    .rw_o   (rw),
    .tw_o   (tw),
    .row_o  (xf_row)
  );

  // finished row to the output buffer
  always_comb begin
    wr_row.bone = 8'(bone_q);
    wr_row.ea   = rw[0];
    wr_row.eb   = rw[1];
    wr_row.ec   = rw[2];
    wr_row.tr   = tw;
    wr_row.bad  = bad_q;
  end

  skf_obuf u_obuf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wr_i          (sum_v_q),
    .wr_row_i      (xf_row),
    .wr_data_i     (wr_row),
    .empty_o       (ob_empty),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // first row pass only starts on a drained buffer
  `SKF_ASSERT_NOW(a_row0_empty, clk_i, rst_ni,
    (state_q == skf_pkg::ST_ROW) && (rc_q == 2'd0), ob_empty)
  // writeback only follows a row pass
  `SKF_ASSERT_NOW(a_wb_window, clk_i, rst_ni, sum_v_q,
    (state_q == skf_pkg::ST_ROW) || (state_q == skf_pkg::ST_TAIL))
  // a root marker is never flagged as a bad parent
  `SKF_ASSERT_NEXT(a_root_not_bad, clk_i, rst_ni, accept && s_axis_tdata[8],
    !bad_q && root_q)

endmodule

`default_nettype wire
